/* hdl/bbs_pkg.sv */
// bbs_pkg: shared types, field widths and defaults for buffered_block_store
// used by bbs_ctrl, bbs_dp and the top level; depends on nothing else
package bbs_pkg;

  localparam int BLK_W     = 8;
  localparam int DATA_W    = 32;
  localparam int ERASE_W   = 4;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  localparam int BLOCK_COUNT_DEF  = 100;
  localparam int BUFFER_DEPTH_DEF = 10;
  localparam int MAX_ERASE_DEF    = 10;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERASE = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_BLOCK = 2'd1,
    ST_BAD_COUNT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_HIT,
    SRC_MEM
  } res_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MREAD,
    S_FLUSH
  } state_t;

  // one buffered command; word holds the erase count for an erase
  typedef struct packed {
    logic              is_erase;
    logic [BLK_W-1:0]  blk;
    logic [DATA_W-1:0] word;
  } cmd_entry_t;

  typedef struct packed {
    logic     load_in;
    logic     append;
    logic     scan_init;
    logic     scan_next;
    logic     flush_init;
    logic     flush_step;
    logic     clear_count;
    logic     res_load;
    status_t  res_status;
    res_src_t res_src;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic blk_bad;
    logic cnt_bad;
    logic buf_empty;
    logic buf_full_next;
    logic buf_full;
    logic scan_hit;
    logic scan_last;
    logic flush_done;
  } dp_stat_t;

endpackage

/* hdl/bbs_ctrl.sv */
// bbs_ctrl: command sequencer for buffered_block_store
// drives bbs_dp through dp_cmd_t and reads dp_stat_t; uses bbs_pkg
module bbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  bbs_pkg::dp_stat_t stat,
  output bbs_pkg::dp_cmd_t  cmd,
  output bbs_pkg::state_t   state
);

  bbs_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == bbs_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign state      = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      bbs_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = bbs_pkg::S_EXEC;
        end
      end
      bbs_pkg::S_EXEC: begin
        priority if (stat.op == bbs_pkg::OP_FLUSH) begin
          cmd.flush_init = 1'b1;
          state_nxt      = bbs_pkg::S_FLUSH;
        end else if (stat.blk_bad) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = bbs_pkg::ST_BAD_BLOCK;
            state_nxt      = bbs_pkg::S_IDLE;
          end
        end else if (stat.op == bbs_pkg::OP_READ) begin
          if (stat.buf_empty) begin
            state_nxt = bbs_pkg::S_MREAD;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = bbs_pkg::S_SCAN;
          end
        end else if (stat.op == bbs_pkg::OP_ERASE && stat.cnt_bad) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = bbs_pkg::ST_BAD_COUNT;
            state_nxt      = bbs_pkg::S_IDLE;
          end
        end else if (stat.buf_full_next) begin
          // last free slot: the buffer drains before the answer
          cmd.append     = 1'b1;
          cmd.flush_init = 1'b1;
          state_nxt      = bbs_pkg::S_FLUSH;
        end else begin
          if (out_free) begin
            cmd.append   = 1'b1;
            cmd.res_load = 1'b1;
            state_nxt    = bbs_pkg::S_IDLE;
          end
        end
      end
      bbs_pkg::S_SCAN: begin
        priority if (stat.scan_hit) begin
          if (out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_src  = bbs_pkg::SRC_HIT;
            state_nxt    = bbs_pkg::S_IDLE;
          end
        end else if (stat.scan_last) begin
          state_nxt = bbs_pkg::S_MREAD;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      bbs_pkg::S_MREAD: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = bbs_pkg::SRC_MEM;
          state_nxt    = bbs_pkg::S_IDLE;
        end
      end
      bbs_pkg::S_FLUSH: begin
        if (!stat.flush_done) begin
          cmd.flush_step = 1'b1;
        end else if (out_free) begin
          cmd.clear_count = 1'b1;
          cmd.res_load    = 1'b1;
          state_nxt       = bbs_pkg::S_IDLE;
        end
      end
      default: state_nxt = bbs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

/* hdl/bbs_dp.sv */
// bbs_dp: datapath of buffered_block_store: input word, command buffer,
// main store with per-block valid bits, scan/flush pointers, result word; uses bbs_pkg
module bbs_dp #(
  parameter int BLOCK_COUNT  = bbs_pkg::BLOCK_COUNT_DEF,
  parameter int BUFFER_DEPTH = bbs_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_ERASE    = bbs_pkg::MAX_ERASE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbs_pkg::dp_cmd_t              cmd,
  output bbs_pkg::dp_stat_t             stat,
  input  logic [bbs_pkg::OP_W-1:0]      in_opcode,
  input  logic [bbs_pkg::BLK_W-1:0]     in_block,
  input  logic [bbs_pkg::DATA_W-1:0]    in_wdata,
  input  logic [bbs_pkg::ERASE_W-1:0]   in_erase_count,
  output logic [bbs_pkg::STATUS_W-1:0]  out_status,
  output logic [bbs_pkg::DATA_W-1:0]    out_read_data
);

  localparam int ADDR_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int PTR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W  = bbs_pkg::BLK_W + 1;

  // latched item
  bbs_pkg::op_t                  op_r;
  logic [bbs_pkg::BLK_W-1:0]     blk_r;
  logic [bbs_pkg::DATA_W-1:0]    wdata_r;
  logic [bbs_pkg::ERASE_W-1:0]   ecnt_r;

  bbs_pkg::cmd_entry_t           buf_r [BUFFER_DEPTH];
  bbs_pkg::cmd_entry_t           cur;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              ptr_r, ptr_nxt;
  logic [bbs_pkg::ERASE_W-1:0]   k_r, k_nxt;

  logic [bbs_pkg::DATA_W-1:0]    store_r [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0]        vld_r;
  logic [bbs_pkg::DATA_W-1:0]    rd_data_r;
  logic                          rd_vld_r;

  logic [bbs_pkg::STATUS_W-1:0]  status_r;
  logic [bbs_pkg::DATA_W-1:0]    data_r;
  logic [bbs_pkg::DATA_W-1:0]    res_data;

  logic [SUM_W-1:0]              cur_lo, cur_hi, blk_ext, erase_addr;
  logic [bbs_pkg::ERASE_W-1:0]   cur_ecnt;
  logic                          entry_done;
  logic                          we;
  logic [ADDR_W-1:0]             waddr;

  assign cur      = buf_r[ptr_r[PTR_W-1:0]];
  assign cur_ecnt = cur.word[bbs_pkg::ERASE_W-1:0];
  assign blk_ext  = {1'b0, blk_r};
  assign cur_lo   = {1'b0, cur.blk};
  assign cur_hi   = cur_lo + SUM_W'(cur_ecnt);
  assign erase_addr = cur_lo + SUM_W'(k_r);

  // status to the sequencer
  always_comb begin
    stat.op            = op_r;
    stat.blk_bad       = blk_ext >= SUM_W'(BLOCK_COUNT);
    stat.cnt_bad       = ecnt_r > bbs_pkg::ERASE_W'(MAX_ERASE);
    stat.buf_empty     = (count_r == '0);
    stat.buf_full_next = (count_r == CNT_W'(BUFFER_DEPTH - 1));
    stat.buf_full      = (count_r >= CNT_W'(BUFFER_DEPTH));
    stat.scan_hit      = cur.is_erase ? (blk_ext >= cur_lo && blk_ext < cur_hi)
                                      : (cur.blk == blk_r);
    stat.scan_last     = (ptr_r == '0);
    stat.flush_done    = (ptr_r == count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= bbs_pkg::op_t'(in_opcode);
      blk_r   <= in_block;
      wdata_r <= in_wdata;
      ecnt_r  <= in_erase_count;
    end
  end

  // command buffer, entries above the fill count are never read
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      buf_r[count_r[PTR_W-1:0]] <= '{
        is_erase: (op_r == bbs_pkg::OP_ERASE),
        blk:      blk_r,
        word:     (op_r == bbs_pkg::OP_ERASE) ? bbs_pkg::DATA_W'(ecnt_r) : wdata_r
      };
    end
  end

  // flush walks one block per cycle; a zero-length erase takes one idle step
  assign entry_done = !cur.is_erase || (cur_ecnt == '0) ||
                      (k_r + bbs_pkg::ERASE_W'(1) == cur_ecnt);

  always_comb begin
    we    = 1'b0;
    waddr = cur.blk[ADDR_W-1:0];
    if (cmd.flush_step) begin
      if (cur.is_erase) begin
        we    = (cur_ecnt != '0) && (erase_addr < SUM_W'(BLOCK_COUNT));
        waddr = erase_addr[ADDR_W-1:0];
      end else begin
        we = cur_lo < SUM_W'(BLOCK_COUNT);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    k_nxt     = k_r;
    if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.clear_count) begin
      count_nxt = '0;
    end
    if (cmd.scan_init) begin
      ptr_nxt = count_r - CNT_W'(1);
    end else if (cmd.scan_next) begin
      ptr_nxt = ptr_r - CNT_W'(1);
    end else if (cmd.flush_init) begin
      ptr_nxt = '0;
      k_nxt   = '0;
    end else if (cmd.flush_step) begin
      if (entry_done) begin
        ptr_nxt = ptr_r + CNT_W'(1);
        k_nxt   = '0;
      end else begin
        k_nxt = k_r + bbs_pkg::ERASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      k_r     <= '0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      k_r     <= k_nxt;
    end
  end

  // main store, read every cycle at the latched block
  always_ff @(posedge clk) begin
    if (we && !cur.is_erase) begin
      store_r[waddr] <= cur.word;
    end
    rd_data_r <= store_r[blk_r[ADDR_W-1:0]];
  end

  // a block that is not valid reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= !cur.is_erase;
      end
      rd_vld_r <= vld_r[blk_r[ADDR_W-1:0]];
    end
  end

  always_comb begin
    unique case (cmd.res_src)
      bbs_pkg::SRC_HIT:  res_data = cur.is_erase ? '0 : cur.word;
      bbs_pkg::SRC_MEM:  res_data = rd_vld_r ? rd_data_r : '0;
      default:           res_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status_r <= cmd.res_status;
      data_r   <= res_data;
    end
  end

  assign out_status    = status_r;
  assign out_read_data = data_r;

endmodule

/* hdl/buffered_block_store.sv */
// buffered_block_store: one item at a time. A read searches the buffered commands,
// newest first, and falls back to the main store when none of them holds the block.
// Errors leave the buffer alone; a write or erase is buffered and answered, after a flush when it fills the
// buffer. A flush steps through each write, each block of an erase run (clipped blocks too) and each empty
// erase. Results sit in an output register, so the next word is taken while one waits.
// rst_n (sync, low) empties the buffer and marks every block zero at once.
module buffered_block_store #(
  parameter int BLOCK_COUNT  = bbs_pkg::BLOCK_COUNT_DEF,
  parameter int BUFFER_DEPTH = bbs_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_ERASE    = bbs_pkg::MAX_ERASE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // block[7:0], wdata[39:8], erase_count[43:40], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  bbs_pkg::dp_cmd_t  cmd;
  bbs_pkg::dp_stat_t stat;
  bbs_pkg::state_t   state;

  bbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .state      (state)
  );

  bbs_dp #(
    .BLOCK_COUNT  (BLOCK_COUNT),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_ERASE    (MAX_ERASE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_tuser),
    .in_block       (in_tdata[7:0]),
    .in_wdata       (in_tdata[39:8]),
    .in_erase_count (in_tdata[43:40]),
    .out_status     (out_tuser),
    .out_read_data  (out_tdata)
  );

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state == bbs_pkg::S_EXEC)
    else $error("accepted word did not move to execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending one");

  // a full buffer only exists while it drains
  a_buf_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.buf_full |-> state == bbs_pkg::S_FLUSH)
    else $error("command buffer left full");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state == bbs_pkg::S_IDLE |-> !cmd.res_load && !cmd.append && !cmd.flush_step)
    else $error("datapath command issued while idle");

endmodule

/* tb/tb_buffered_block_store.sv */
// tb_buffered_block_store: self-checking bench for the buffered block store
// runs a directed table of words and then random traffic with gaps on both sides
// depends on bbs_pkg and the buffered_block_store rtl
module tb_buffered_block_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK_W        = bbs_pkg::BLK_W;
  localparam int DATA_W       = bbs_pkg::DATA_W;
  localparam int ERASE_W      = bbs_pkg::ERASE_W;
  localparam int BLOCKS       = bbs_pkg::BLOCK_COUNT_DEF;
  localparam int DEPTH        = bbs_pkg::BUFFER_DEPTH_DEF;
  localparam int ERASE_MAX    = bbs_pkg::MAX_ERASE_DEF;
  localparam int DIRECTED_N   = 25;
  localparam int RANDOM_WORDS = 1300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    bbs_pkg::op_t       op;
    logic [BLK_W-1:0]   blk;
    logic [DATA_W-1:0]  wdata;
    logic [ERASE_W-1:0] cnt;
    logic               typed;
    bbs_pkg::status_t   st;
    logic [DATA_W-1:0]  rdata;
  } stim_row_t;

  typedef struct {
    bbs_pkg::status_t  st;
    logic [DATA_W-1:0] rdata;
    int                idx;
  } read_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // block[7:0], wdata[39:8], erase_count[43:40], zero pad
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // read_data[31:0]
  logic [1:0]  out_tuser;       // status[1:0]

  // predicted image of the store and its command buffer
  logic [DATA_W-1:0]   store_image [BLOCKS];
  bbs_pkg::cmd_entry_t pend_cmds [DEPTH];
  int                  pend_count;

  read_result_t      expected_results [$];
  read_result_t      head_result;
  stim_row_t         directed_rows [DIRECTED_N];
  int                words_sent = 0;
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                quiet = 1'b0;
  logic [BLK_W-1:0]  hot_blk = '0;

  buffered_block_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void replay_pending();
    int b;
    for (int i = 0; i < pend_count; i++) begin
      if (pend_cmds[i].is_erase) begin
        for (int k = 0; k < int'(pend_cmds[i].word); k++) begin
          b = int'(pend_cmds[i].blk) + k;
          // erase runs stop at the end of the store
          if (b < BLOCKS) store_image[b] = '0;
        end
      end else begin
        store_image[pend_cmds[i].blk] = pend_cmds[i].word;
      end
    end
    pend_count = 0;
  endfunction

  function automatic void buffer_cmd(logic is_erase, logic [BLK_W-1:0] blk,
                                     logic [DATA_W-1:0] word);
    pend_cmds[pend_count].is_erase = is_erase;
    pend_cmds[pend_count].blk      = blk;
    pend_cmds[pend_count].word     = word;
    pend_count++;
    if (pend_count >= DEPTH) replay_pending();
  endfunction

  function automatic logic [DATA_W-1:0] lookup_block(int blk);
    int lo;
    int hi;
    // newest buffered command wins
    for (int i = pend_count - 1; i >= 0; i--) begin
      lo = int'(pend_cmds[i].blk);
      if (!pend_cmds[i].is_erase) begin
        if (lo == blk) return pend_cmds[i].word;
      end else begin
        hi = lo + int'(pend_cmds[i].word);
        if (blk >= lo && blk < hi) return '0;
      end
    end
    return store_image[blk];
  endfunction

  function automatic void predict_result(bbs_pkg::op_t op, logic [BLK_W-1:0] blk,
                                         logic [DATA_W-1:0] wdata, logic [ERASE_W-1:0] cnt,
                                         output bbs_pkg::status_t st,
                                         output logic [DATA_W-1:0] rdata);
    st = bbs_pkg::ST_OK;
    rdata = '0;
    if (op == bbs_pkg::OP_FLUSH) replay_pending();
    else if (int'(blk) >= BLOCKS) st = bbs_pkg::ST_BAD_BLOCK;
    else if (op == bbs_pkg::OP_READ) rdata = lookup_block(int'(blk));
    else if (op == bbs_pkg::OP_WRITE) buffer_cmd(1'b0, blk, wdata);
    else if (int'(cnt) > ERASE_MAX) st = bbs_pkg::ST_BAD_COUNT;
    else buffer_cmd(1'b1, blk, DATA_W'(cnt));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
    $display("mismatch on word %0d: %s got %h want %h", idx, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(bbs_pkg::op_t op, logic [BLK_W-1:0] blk,
                           logic [DATA_W-1:0] wdata, logic [ERASE_W-1:0] cnt,
                           logic typed, bbs_pkg::status_t t_st,
                           logic [DATA_W-1:0] t_rdata);
    bbs_pkg::status_t  st;
    logic [DATA_W-1:0] rd;
    int                gap;
    read_result_t      exp_item;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, cnt, wdata, blk};
    do @(posedge clk); while (!in_tready);
    predict_result(op, blk, wdata, cnt, st, rd);
    if (typed) begin
      st = t_st;
      rd = t_rdata;
    end
    exp_item.st    = st;
    exp_item.rdata = rd;
    exp_item.idx   = words_sent;
    expected_results.insert(expected_results.size(), exp_item);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: check each accepted word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", -1, out_tdata, '0);
      end else begin
        head_result = expected_results.pop_front();
        if (out_tuser !== head_result.st)
          report_mismatch("status", head_result.idx, 32'(out_tuser), 32'(head_result.st));
        if (out_tdata !== head_result.rdata)
          report_mismatch("read_data", head_result.idx, out_tdata, head_result.rdata);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_buffered_block_store failed");
      $finish;
    end
  end

  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    out_tready <= 1'b1;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    bbs_pkg::op_t       op;
    logic [BLK_W-1:0]   blk;
    logic [DATA_W-1:0]  wd;
    logic [ERASE_W-1:0] cnt;
    int                 pick;
    for (int b = 0; b < BLOCKS; b++) store_image[b] = '0;
    pend_count = 0;
    directed_rows = '{
      '{bbs_pkg::OP_READ,  8'd0,   32'h0000_0000, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd99,  32'h0000_0000, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd100, 32'h0000_0000, 4'd0,  1'b1, bbs_pkg::ST_BAD_BLOCK, 32'h0},
      '{bbs_pkg::OP_READ,  8'd255, 32'hFFFF_FFFF, 4'd15, 1'b1, bbs_pkg::ST_BAD_BLOCK, 32'h0},
      '{bbs_pkg::OP_WRITE, 8'd255, 32'hFFFF_FFFF, 4'd0,  1'b1, bbs_pkg::ST_BAD_BLOCK, 32'h0},
      // bad block is reported ahead of a bad count
      '{bbs_pkg::OP_ERASE, 8'd255, 32'h0000_0000, 4'd15, 1'b1, bbs_pkg::ST_BAD_BLOCK, 32'h0},
      '{bbs_pkg::OP_ERASE, 8'd0,   32'h0000_0000, 4'd11, 1'b1, bbs_pkg::ST_BAD_COUNT, 32'h0},
      '{bbs_pkg::OP_ERASE, 8'd99,  32'h0000_0000, 4'd15, 1'b1, bbs_pkg::ST_BAD_COUNT, 32'h0},
      // flush of an empty buffer, other fields ignored
      '{bbs_pkg::OP_FLUSH, 8'd255, 32'hFFFF_FFFF, 4'd15, 1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_WRITE, 8'd0,   32'hFFFF_FFFF, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_WRITE, 8'd99,  32'hA5A5_5A5A, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd0,   32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd99,  32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      // erase run that runs past the last block
      '{bbs_pkg::OP_ERASE, 8'd95,  32'h0000_0000, 4'd10, 1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd99,  32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_ERASE, 8'd5,   32'h0000_0000, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_WRITE, 8'd5,   32'h1234_5678, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd5,   32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_ERASE, 8'd0,   32'h0000_0000, 4'd10, 1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd0,   32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd10,  32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_FLUSH, 8'd0,   32'h0000_0000, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd99,  32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_READ,  8'd5,   32'h0000_0000, 4'd0,  1'b0, bbs_pkg::ST_OK,        32'h0},
      '{bbs_pkg::OP_WRITE, 8'd1,   32'h0000_0000, 4'd0,  1'b1, bbs_pkg::ST_OK,        32'h0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < DIRECTED_N; n++)
      send_word(directed_rows[n].op, directed_rows[n].blk, directed_rows[n].wdata,
                directed_rows[n].cnt, directed_rows[n].typed, directed_rows[n].st,
                directed_rows[n].rdata);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 400 && n < 600);
      pick = $urandom_range(0, 99);
      if (pick < 38) op = bbs_pkg::OP_READ;
      else if (pick < 70) op = bbs_pkg::OP_WRITE;
      else if (pick < 94) op = bbs_pkg::OP_ERASE;
      else op = bbs_pkg::OP_FLUSH;
      // for 28 percent of words, pick a block near the latest write or erase so reads hit the buffer
      pick = $urandom_range(0, 99);
      if (pick < 8) blk = BLK_W'($urandom_range(BLOCKS, 255));
      else if (pick < 22) blk = BLK_W'($urandom_range(BLOCKS - 10, BLOCKS - 1));
      else if (pick < 50) blk = hot_blk + BLK_W'($urandom_range(0, 3));
      else blk = BLK_W'($urandom_range(0, BLOCKS - 1));
      if ((op == bbs_pkg::OP_WRITE || op == bbs_pkg::OP_ERASE) && int'(blk) < BLOCKS)
        hot_blk = blk;
      if ($urandom_range(0, 99) < 12) cnt = ERASE_W'($urandom_range(ERASE_MAX + 1, 15));
      else cnt = ERASE_W'($urandom_range(0, ERASE_MAX));
      pick = $urandom_range(0, 19);
      if (pick == 0) wd = '0;
      else if (pick == 1) wd = '1;
      else wd = $urandom;
      send_word(op, blk, wd, cnt, 1'b0, bbs_pkg::ST_OK, '0);
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_buffered_block_store passed");
    end else begin
      $display("tb_buffered_block_store failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bbs_pkg.sv
hdl/bbs_ctrl.sv
hdl/bbs_dp.sv
hdl/buffered_block_store.sv
tb/tb_buffered_block_store.sv
